>>> rtl/stl_pkg.sv
`timescale 1ns / 1ps
// Shared types, token kind codes and keyword tables for the script token lexer.
// Depends on nothing; imported by script_token_lexer_unit.
package stl_pkg;

   localparam int POS_BITS_DEF = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int KW_COUNT     = 10;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_USCORE = 8'h5F;

   typedef enum logic [5:0] {
      KIND_PRINT  = 6'd0,  KIND_WHILE = 6'd1,  KIND_IF     = 6'd2,  KIND_ELIF   = 6'd3,
      KIND_ELSE   = 6'd4,  KIND_NOT   = 6'd5,  KIND_AND    = 6'd6,  KIND_OR     = 6'd7,
      KIND_TRUE   = 6'd8,  KIND_FALSE = 6'd9,  KIND_EOL    = 6'd10, KIND_EOF    = 6'd11,
      KIND_ERROR  = 6'd12, KIND_FLOAT = 6'd13, KIND_INT    = 6'd14, KIND_IDENT  = 6'd15,
      KIND_PLUS   = 6'd16, KIND_MINUS = 6'd17, KIND_MULT   = 6'd18, KIND_MOD    = 6'd19,
      KIND_LPAR   = 6'd20, KIND_RPAR  = 6'd21, KIND_COLON  = 6'd22, KIND_NEQ    = 6'd23,
      KIND_DIVI   = 6'd24, KIND_DIV   = 6'd25, KIND_EQ     = 6'd26, KIND_ASSIGN = 6'd27,
      KIND_GE     = 6'd28, KIND_GT    = 6'd29, KIND_LE     = 6'd30, KIND_LT     = 6'd31,
      KIND_BAD    = 6'd32
   } kind_type;

   // Terminator classes: space or '(', also ':', or any non-alphanumeric byte.
   typedef enum logic [1:0] {TERM_PLAIN, TERM_COLON, TERM_NONALNUM} term_type;

   typedef struct packed {
      kind_type     kind;
      logic [15:0]  text_start;
      logic [15:0]  text_len;
      logic [30:0]  int_value;
      logic         last;
   } tok_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } kw_hit_type;

   // Keyword text packed first byte lowest, zero padded to five bytes.
   localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
      40'h74_6e_69_72_70, 40'h65_6c_69_68_77, 40'h00_00_00_66_69,
      40'h00_66_69_6c_65, 40'h00_65_73_6c_65, 40'h00_00_74_6f_6e,
      40'h00_00_64_6e_61, 40'h00_00_00_72_6f, 40'h00_65_75_72_54,
      40'h65_73_6c_61_46
   };
   localparam logic [15:0] KW_LEN [KW_COUNT] = '{
      16'd5, 16'd5, 16'd2, 16'd4, 16'd4, 16'd3, 16'd3, 16'd2, 16'd4, 16'd5
   };
   localparam term_type KW_TERM [KW_COUNT] = '{
      TERM_PLAIN, TERM_PLAIN, TERM_PLAIN, TERM_PLAIN, TERM_COLON,
      TERM_PLAIN, TERM_PLAIN, TERM_PLAIN, TERM_NONALNUM, TERM_NONALNUM
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || is_alpha(c);
   endfunction

   function automatic logic [15:0] len_inc(input logic [15:0] n);
      return (n == 16'hFFFF) ? n : n + 16'd1;
   endfunction

   // Keyword whose text equals the held identifier; the ten compares run side by side.
   function automatic kw_hit_type kw_lookup(input logic [15:0] len, input logic [39:0] text);
      kw_hit_type r;
      r = '0;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if ((len == KW_LEN[k]) && (text == KW_TEXT[k])) begin
            r.hit = 1'b1;
            r.idx = 4'(k);
         end
      end
      return r;
   endfunction

   function automatic logic kw_term_ok(input logic [3:0] idx, input logic [7:0] c);
      logic ok;
      ok = 1'b0;
      unique case (KW_TERM[idx])
         TERM_NONALNUM: ok = !is_alnum(c);
         TERM_COLON:    ok = (c == CH_SPACE) || (c == CH_LPAR) || (c == CH_COLON);
         TERM_PLAIN:    ok = (c == CH_SPACE) || (c == CH_LPAR);
         default:       ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

>>> rtl/script_token_lexer_unit.sv
`timescale 1ns / 1ps
// Streaming tokenizer: one source byte in, up to two tokens out, through a result queue.
// Depends on stl_pkg for token kinds, keyword tables and character helpers.
//
//  Channel   Ports                                            Direction
//  --------  -----------------------------------------------  ---------
//  request   req_valid, req_ready, req_ch                     in
//  response  rsp_valid, rsp_ready, rsp_kind, rsp_text_start,  out
//            rsp_text_len, rsp_int_value, rsp_last
//
// Each accepted byte is scanned in the cycle it is accepted: the scanner state registers and
// the tokens it finishes are updated at that same clock edge, so one byte per cycle is taken
// while the queue has room. Tokens wait in a four-entry queue; a byte is taken whenever at
// least two entries are free, so a slow or stalled response side holds off the request side
// once fewer than two entries are free. The response side drains one token per cycle while
// rsp_ready is high, which bounds the rate for bytes that end two tokens at once. Reset
// (synchronous, active high) returns the scanner to idle with position zero and empties the queue.
module script_token_lexer_unit
   import stl_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_ch,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [5:0]   rsp_kind,
   output logic [15:0]  rsp_text_start,
   output logic [15:0]  rsp_text_len,
   output logic [30:0]  rsp_int_value,
   output logic         rsp_last
);

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {M_IDLE, M_NUM, M_ERR, M_IDENT, M_OP} mode_type;

   // Scanner state.
   mode_type              mode_ff,   mode_in;
   logic [POS_BITS-1:0]   pos_ff,    pos_in;
   logic [POS_BITS-1:0]   tstart_ff, tstart_in;
   logic [15:0]           len_ff,    len_in;
   logic [39:0]           prefix_ff, prefix_in;
   logic [30:0]           accum_ff,  accum_in;
   logic                  dot_ff,    dot_in;
   logic [7:0]            held_ff,   held_in;

   // Result queue.
   tok_type               q_ff [QUEUE_DEPTH];
   logic [QW-1:0]         wr_ff, wr_in;
   logic [QW-1:0]         rd_ff, rd_in;
   logic [QW:0]           cnt_ff, cnt_in;

   logic                  accept;
   logic                  pop;
   logic [7:0]            c;
   logic [POS_BITS-1:0]   p;
   logic [15:0]           p16;
   logic [15:0]           ts16;

   // Tokens finished by this byte: the one it ends, then the one it starts and completes.
   logic                  end_v;
   tok_type               end_tok;
   logic                  new_v;
   tok_type               new_tok;
   logic                  do_fresh;
   kw_hit_type            kw;
   logic [34:0]           prod;
   logic                  emit2;
   logic [1:0]            n_push;
   tok_type               slot0, slot1;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff <= (QW+1)'(QUEUE_DEPTH - 2));
   assign rsp_valid = (cnt_ff != '0);

   assign c    = req_ch;
   assign p    = pos_ff;
   assign p16  = 16'(pos_ff);
   assign ts16 = 16'(tstart_ff);

   // Decimal accumulate as shift-and-add, saturated at the largest 31-bit value.
   assign prod = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1) + 35'(c - 8'h30);
   assign kw   = kw_lookup(len_ff, prefix_ff);

   always_comb begin
      mode_in   = mode_ff;
      tstart_in = tstart_ff;
      len_in    = len_ff;
      prefix_in = prefix_ff;
      accum_in  = accum_ff;
      dot_in    = dot_ff;
      held_in   = held_ff;
      end_v     = 1'b0;
      end_tok   = '0;
      new_v     = 1'b0;
      new_tok   = '0;
      do_fresh  = 1'b0;

      // First part: the token under way either absorbs the byte or ends before it.
      unique case (mode_ff)
         M_NUM: begin
            if (is_digit(c) || (c == CH_DOT)) begin
               if (c == CH_DOT) begin
                  dot_in = 1'b1;
               end else begin
                  accum_in = (prod > {4'b0, INT_SAT}) ? INT_SAT : prod[30:0];
               end
               len_in = len_inc(len_ff);
            end else if (is_alpha(c)) begin
               // A letter glued to a number turns the whole run into an error token.
               mode_in = M_ERR;
               len_in  = len_inc(len_ff);
            end else begin
               end_v              = 1'b1;
               end_tok.kind       = dot_ff ? KIND_FLOAT : KIND_INT;
               end_tok.text_start = ts16;
               end_tok.text_len   = len_ff;
               end_tok.int_value  = dot_ff ? '0 : accum_ff;
               do_fresh           = 1'b1;
            end
         end
         M_ERR: begin
            if ((c == CH_SPACE) || (c == CH_NL) || (c == CH_NUL)) begin
               end_v              = 1'b1;
               end_tok.kind       = KIND_ERROR;
               end_tok.text_start = ts16;
               end_tok.text_len   = len_ff;
               do_fresh           = 1'b1;
            end else begin
               len_in = len_inc(len_ff);
            end
         end
         M_IDENT: begin
            if (is_alnum(c) || (c == CH_USCORE)) begin
               if ((c == CH_USCORE) && kw.hit &&
                   ((kw.idx == 4'(KIND_TRUE)) || (kw.idx == 4'(KIND_FALSE)))) begin
                  // True or False right before an underscore: the keyword stands on its own
                  // and the underscore opens the next identifier.
                  end_v              = 1'b1;
                  end_tok.kind       = kind_type'(6'(kw.idx));
                  end_tok.text_start = ts16;
                  end_tok.text_len   = len_ff;
                  end_tok.int_value  = 31'(kw.idx == 4'(KIND_TRUE));
                  mode_in            = M_IDENT;
                  tstart_in          = p;
                  len_in             = 16'd1;
                  prefix_in          = {32'b0, c};
               end else begin
                  // Only the first five bytes are kept; that covers every keyword.
                  if (len_ff < 16'd5) begin
                     prefix_in[8*len_ff[2:0] +: 8] = c;
                  end
                  len_in = len_inc(len_ff);
               end
            end else begin
               end_v              = 1'b1;
               end_tok.text_start = ts16;
               end_tok.text_len   = len_ff;
               if (kw.hit && kw_term_ok(kw.idx, c)) begin
                  end_tok.kind      = kind_type'(6'(kw.idx));
                  end_tok.int_value = 31'(kw.idx == 4'(KIND_TRUE));
               end else begin
                  end_tok.kind = KIND_IDENT;
               end
               do_fresh = 1'b1;
            end
         end
         M_OP: begin
            logic     second;
            kind_type pair_k, single_k;
            second   = (c == CH_EQ);
            pair_k   = KIND_BAD;
            single_k = KIND_BAD;
            priority case (held_ff)
               CH_BANG:  begin pair_k = KIND_NEQ; end
               CH_SLASH: begin second = (c == CH_SLASH); pair_k = KIND_DIVI;
                               single_k = KIND_DIV; end
               CH_EQ:    begin pair_k = KIND_EQ; single_k = KIND_ASSIGN; end
               CH_GT:    begin pair_k = KIND_GE; single_k = KIND_GT; end
               CH_LT:    begin pair_k = KIND_LE; single_k = KIND_LT; end
               default:  begin second = 1'b0; end
            endcase
            held_in            = '0;
            end_v              = 1'b1;
            end_tok.text_start = ts16;
            if (second) begin
               end_tok.kind     = pair_k;
               end_tok.text_len = 16'd2;
               mode_in          = M_IDLE;
            end else begin
               // A lone '!' falls out here as an unexpected character.
               end_tok.kind     = single_k;
               end_tok.text_len = 16'd1;
               do_fresh         = 1'b1;
            end
         end
         default: begin
            do_fresh = 1'b1;
         end
      endcase

      // Second part: the byte is scanned as the start of something new.
      if (do_fresh) begin
         mode_in            = M_IDLE;
         new_tok.text_start = p16;
         new_tok.text_len   = 16'd1;
         if ((c == CH_SPACE) || (c == CH_TAB)) begin
            new_v = 1'b0;
         end else if (c == CH_NL) begin
            new_v        = 1'b1;
            new_tok.kind = KIND_EOL;
         end else if (c == CH_NUL) begin
            new_v            = 1'b1;
            new_tok.kind     = KIND_EOF;
            new_tok.text_len = 16'd0;
         end else if (is_digit(c)) begin
            mode_in   = M_NUM;
            tstart_in = p;
            len_in    = 16'd1;
            accum_in  = 31'(c - 8'h30);
            dot_in    = 1'b0;
         end else if (is_alpha(c) || (c == CH_USCORE)) begin
            mode_in   = M_IDENT;
            tstart_in = p;
            len_in    = 16'd1;
            prefix_in = {32'b0, c};
         end else begin
            priority case (c)
               CH_PLUS:  begin new_v = 1'b1; new_tok.kind = KIND_PLUS;  end
               CH_MINUS: begin new_v = 1'b1; new_tok.kind = KIND_MINUS; end
               CH_STAR:  begin new_v = 1'b1; new_tok.kind = KIND_MULT;  end
               CH_PCT:   begin new_v = 1'b1; new_tok.kind = KIND_MOD;   end
               CH_LPAR:  begin new_v = 1'b1; new_tok.kind = KIND_LPAR;  end
               CH_RPAR:  begin new_v = 1'b1; new_tok.kind = KIND_RPAR;  end
               CH_COLON: begin new_v = 1'b1; new_tok.kind = KIND_COLON; end
               CH_BANG, CH_SLASH, CH_EQ, CH_GT, CH_LT: begin
                  // Possible two-byte operator: hold it until the next byte decides.
                  mode_in   = M_OP;
                  held_in   = c;
                  tstart_in = p;
               end
               default:  begin new_v = 1'b1; new_tok.kind = KIND_BAD; end
            endcase
         end
      end
   end

   // The end-of-input byte restarts offsets at zero for the next input.
   assign pos_in = (c == CH_NUL) ? '0 : p + 1'b1;

   // Pack the finished tokens into queue slots and mark the last one of this byte.
   always_comb begin
      emit2 = end_v && new_v;
      slot0 = end_v ? end_tok : new_tok;
      slot1 = new_tok;
      slot0.last = !emit2;
      slot1.last = 1'b1;
      n_push = 2'(end_v) + 2'(new_v);
   end

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         wr_in = wr_ff + QW'(n_push);
      end
      if (pop) begin
         rd_in = rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + (QW+1)'(accept ? n_push : 2'd0) - (QW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         pos_ff    <= '0;
         tstart_ff <= '0;
         len_ff    <= '0;
         prefix_ff <= '0;
         accum_ff  <= '0;
         dot_ff    <= 1'b0;
         held_ff   <= '0;
         wr_ff     <= '0;
         rd_ff     <= '0;
         cnt_ff    <= '0;
      end else begin
         if (accept) begin
            mode_ff   <= mode_in;
            pos_ff    <= pos_in;
            tstart_ff <= tstart_in;
            len_ff    <= len_in;
            prefix_ff <= prefix_in;
            accum_ff  <= accum_in;
            dot_ff    <= dot_in;
            held_ff   <= held_in;
         end
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue entries carry payload only; the count says which are live.
   always_ff @(posedge clock) begin
      if (accept && (n_push != 2'd0)) begin
         q_ff[wr_ff] <= slot0;
         if (emit2) begin
            q_ff[wr_ff + 1'b1] <= slot1;
         end
      end
   end

   assign rsp_kind       = q_ff[rd_ff].kind;
   assign rsp_text_start = q_ff[rd_ff].text_start;
   assign rsp_text_len   = q_ff[rd_ff].text_len;
   assign rsp_int_value  = q_ff[rd_ff].int_value;
   assign rsp_last       = q_ff[rd_ff].last;

   // The queue never holds more tokens than it has entries.
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QW+1)'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // The queue count follows the pointers.
   a_queue_ptrs : assert property (@(posedge clock) disable iff (reset)
      (wr_ff - rd_ff) == cnt_ff[QW-1:0])
      else $error("result queue pointers disagree with count");

   // An accepted end-of-input byte leaves the position at zero.
   a_eof_pos : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch == CH_NUL)) |=> (pos_ff == '0))
      else $error("position not restarted after end of input");

   // A held operator byte is present exactly while an operator is pending.
   a_held_op : assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_OP) |-> (held_ff != '0))
      else $error("operator mode without a held operator");

endmodule
